@@ rtl/window_stddev_occupancy_unit_defines.svh @@
// Assertion macros shared by the checker of the window occupancy unit.
`ifndef WINDOW_STDDEV_OCCUPANCY_UNIT_DEFINES_SVH
`define WINDOW_STDDEV_OCCUPANCY_UNIT_DEFINES_SVH

// Same-cycle implication, disabled while dis is high.
`define WSD_ASSERT_NOW(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled while dis is high.
`define WSD_ASSERT_NEXT(label, clk, dis, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (dis) (ante) |=> (cons)) \
    else $error(msg);

`endif

@@ rtl/wsd_pkg.sv @@
// Shared types and constants of the window occupancy unit.
`default_nettype none

package wsd_pkg;

  localparam int SAMPLE_W = 18;
  localparam int THRESH_W = 18;
  localparam int MOVE_W   = 8;
  localparam int MOVE_DIV = 10;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [THRESH_W-1:0] THRESH_RESET = THRESH_W'(9000);

  // Word handed from the front to the back.
  typedef struct packed {
    logic                ready;
    logic [SAMPLE_W-1:0] sample;
  } job_t;

  // Word delivered on the result ports.
  typedef struct packed {
    logic              ready_res;
    logic              leave_bed;
    logic [MOVE_W-1:0] movement_level;
  } result_t;

  // Sample bits actually kept: the port carries at most SAMPLE_W.
  function automatic int eff_bits(int bits);
    return (bits < SAMPLE_W) ? bits : SAMPLE_W;
  endfunction

endpackage

`default_nettype wire

@@ rtl/wsd_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
`default_nettype none

module wsd_ram #(
  parameter int WIDTH = 18,
  parameter int DEPTH = 10
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

@@ rtl/wsd_fifo.sv @@
// Small register queue used between the front and back and on the result side.
`default_nettype none

module wsd_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             push,
  input  wire logic [WIDTH-1:0] wdata,
  output logic                  full,
  input  wire logic             pop,
  output logic      [WIDTH-1:0] rdata,
  output logic                  empty
);

  localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CW = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PW-1:0]    wr_ptr;
  logic [PW-1:0]    rd_ptr;
  logic [CW-1:0]    count;
  logic             do_push;
  logic             do_pop;

  assign full    = (count == CW'(DEPTH));
  assign empty   = (count == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PW'(DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PW'(DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsd_front.sv @@
// Front part: accepts samples, masks them and tags each with its fill state.
`default_nettype none

module wsd_front import wsd_pkg::*; #(
  parameter int FILL_LENGTH = 200,
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  input  wire logic [SAMPLE_W-1:0] sample_sum,
  input  wire logic                q_full,
  output logic                     job_push,
  output job_t                     job
);

  localparam int SW  = eff_bits(SAMPLE_BITS);
  localparam int FCW = $clog2(FILL_LENGTH + 1);
  localparam logic [SAMPLE_W-1:0] SAMPLE_MASK = {SAMPLE_W{1'b1}} >> (SAMPLE_W - SW);

  logic [FCW-1:0] fill_count;

  assign job_push   = push && !q_full;
  assign job.sample = sample_sum & SAMPLE_MASK;
  // This sample is the one that completes the fill, or the fill is already done.
  assign job.ready  = (fill_count >= FCW'(FILL_LENGTH - 1));

  always_ff @(posedge clk) begin
    if (rst) begin
      fill_count <= '0;
    end else if (job_push && (fill_count != FCW'(FILL_LENGTH))) begin
      fill_count <= fill_count + 1'b1;
    end
  end

endmodule

`default_nettype wire

@@ rtl/wsd_back.sv @@
// Back part: updates the sample ring, sweeps it and computes the result word.
`default_nettype none

module wsd_back import wsd_pkg::*; #(
  parameter int WINDOW      = 10,
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                job_empty,
  input  wire job_t                job,
  output logic                     job_pop,
  input  wire logic [THRESH_W-1:0] thr,
  input  wire logic                res_full,
  output logic                     res_push,
  output result_t                  res
);

  localparam int SW    = eff_bits(SAMPLE_BITS);
  localparam int AW    = $clog2(WINDOW);
  localparam int ICW   = $clog2(WINDOW + 1);
  localparam int WW    = $clog2(WINDOW + 1);
  localparam int SUM_W = SW + AW;
  localparam int QW    = 2 * SW + AW;
  localparam int NW    = 2 * SW + AW + WW;
  localparam int KW    = $clog2(MOVE_DIV * WINDOW + 1);
  localparam int PRW   = KW + MOVE_W;
  localparam int CW    = (NW > 2 * PRW) ? NW : 2 * PRW;
  localparam int BIW   = $clog2(MOVE_W);

  localparam logic [WW-1:0] W_CONST = WW'(WINDOW);
  localparam logic [KW-1:0] K_MOVE  = KW'(MOVE_DIV * WINDOW);

  typedef enum logic [2:0] {
    S_IDLE,
    S_SWEEP,
    S_SQUARE,
    S_DIFF,
    S_SRCH_MUL,
    S_SRCH_CMP,
    S_PUSH
  } state_t;

  state_t            state;
  logic [AW-1:0]     wptr;
  logic [ICW-1:0]    issue_cnt;
  logic              rd_v;
  logic              sq_v;
  logic [2*SW-1:0]   sq;
  logic [SUM_W-1:0]  s_acc;
  logic [QW-1:0]     q_acc;
  logic              leave;
  logic [NW-1:0]     wq;
  logic [2*SUM_W-1:0] ss;
  logic [NW-1:0]     n_val;
  logic [MOVE_W-1:0] m_val;
  logic [BIW-1:0]    bit_idx;
  logic [PRW-1:0]    prod;
  logic [2*PRW-1:0]  prod_sq;
  logic [MOVE_W-1:0] trial;
  logic              issue;
  logic              fits;
  logic [SW-1:0]     rdata;

  assign job_pop  = (state == S_IDLE) && !job_empty;
  assign res_push = (state == S_PUSH);
  assign issue    = (state == S_SWEEP) && (issue_cnt != ICW'(WINDOW));

  always_comb begin
    trial   = m_val | (MOVE_W'(1) << bit_idx);
    prod_sq = prod * prod;
    fits    = (CW'(prod_sq) <= CW'(n_val));
  end

  wsd_ram #(
    .WIDTH (SW),
    .DEPTH (WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (job_pop),
    .waddr (wptr),
    .wdata (job.sample[SW-1:0]),
    .raddr (issue_cnt[AW-1:0]),
    .rdata (rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      wptr  <= '0;
      rd_v  <= 1'b0;
      sq_v  <= 1'b0;
    end else begin
      rd_v <= issue;
      sq_v <= rd_v;
      case (state)
        S_IDLE: begin
          if (!job_empty) begin
            wptr <= (wptr == AW'(WINDOW - 1)) ? '0 : wptr + 1'b1;
            if (job.ready) begin
              issue_cnt <= '0;
              s_acc     <= '0;
              q_acc     <= '0;
              leave     <= 1'b1;
              state     <= S_SWEEP;
            end else begin
              res   <= '0;
              state <= S_PUSH;
            end
          end
        end
        S_SWEEP: begin
          if (issue) begin
            issue_cnt <= issue_cnt + 1'b1;
          end
          if (rd_v) begin
            s_acc <= s_acc + SUM_W'(rdata);
            sq    <= rdata * rdata;
            if (THRESH_W'(rdata) > thr) begin
              leave <= 1'b0;
            end
          end
          if (sq_v) begin
            q_acc <= q_acc + QW'(sq);
          end
          // Leave once every read has been folded into both sums.
          if (!issue && !rd_v && !sq_v) begin
            state <= S_SQUARE;
          end
        end
        S_SQUARE: begin
          wq    <= NW'(q_acc) * NW'(W_CONST);
          ss    <= s_acc * s_acc;
          state <= S_DIFF;
        end
        S_DIFF: begin
          // W*Q - S*S is the pairwise sum of squared differences.
          n_val   <= wq - NW'(ss);
          m_val   <= '0;
          bit_idx <= BIW'(MOVE_W - 1);
          state   <= S_SRCH_MUL;
        end
        S_SRCH_MUL: begin
          prod  <= K_MOVE * trial;
          state <= S_SRCH_CMP;
        end
        S_SRCH_CMP: begin
          // Keep the bit while (10*W*m)^2 still fits under the sum.
          if (bit_idx == '0) begin
            res.ready_res      <= 1'b1;
            res.leave_bed      <= leave;
            res.movement_level <= fits ? trial : m_val;
            state              <= S_PUSH;
          end else begin
            if (fits) begin
              m_val <= trial;
            end
            bit_idx <= bit_idx - 1'b1;
            state   <= S_SRCH_MUL;
          end
        end
        S_PUSH: begin
          if (!res_full) begin
            state <= S_IDLE;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

`default_nettype wire

@@ rtl/window_stddev_occupancy_unit.sv @@
// Top level of the sliding-window occupancy and movement unit.
// Usage:
//   Input channel: drive sample_sum and raise push; the word is taken at a
//   clock edge with push high and full low. Results come out of a queue:
//   while empty is low the oldest result sits on ready_res, leave_bed and
//   movement_level, and pop takes it. Every sample yields one result.
//   cfg_data is written into the occupancy threshold when cfg_valid is high;
//   cfg_ready is always high. Write it only while no sample is in flight.
// Flow: a two-word queue parts the front from the back. During the fill
//   the back stores each sample in the ring and pushes an all-zero result.
//   After the fill the back sweeps the ring of WINDOW samples through one
//   RAM read port, squares the sums, takes their difference and runs
//   an 8-step binary search for the movement level, each step a multiply
//   and a compare. The back takes no new sample until its result is pushed.
// Reset: clears both queues, the fill count and the ring pointer, and loads
//   a threshold of 9000. Ring contents stay undefined until written.
// Stall: when the result queue fills, the back holds; the input queue then
//   fills and full rises until pop frees room.
`default_nettype none

module window_stddev_occupancy_unit import wsd_pkg::*; #(
  parameter int WINDOW      = 10,
  parameter int FILL_LENGTH = 200,
  parameter int SAMPLE_BITS = 18
) (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                push,
  output logic                     full,
  input  wire logic [SAMPLE_W-1:0] sample_sum,
  output logic                     empty,
  input  wire logic                pop,
  output logic                     ready_res,
  output logic                     leave_bed,
  output logic      [MOVE_W-1:0]   movement_level,
  input  wire logic                cfg_valid,
  output logic                     cfg_ready,
  input  wire logic [THRESH_W-1:0] cfg_data
);

  logic [THRESH_W-1:0] thr;
  logic                job_push;
  job_t                job_in;
  job_t                job_out;
  logic                job_empty;
  logic                job_pop;
  logic                res_full;
  logic                res_push;
  result_t             res_in;
  result_t             res_out;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      thr <= THRESH_RESET;
    end else if (cfg_valid && cfg_ready) begin
      thr <= cfg_data;
    end
  end

  wsd_front #(
    .FILL_LENGTH (FILL_LENGTH),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .sample_sum (sample_sum),
    .q_full     (full),
    .job_push   (job_push),
    .job        (job_in)
  );

  wsd_fifo #(
    .WIDTH ($bits(job_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_job_q (
    .clk   (clk),
    .rst   (rst),
    .push  (job_push),
    .wdata (job_in),
    .full  (full),
    .pop   (job_pop),
    .rdata (job_out),
    .empty (job_empty)
  );

  wsd_back #(
    .WINDOW      (WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk       (clk),
    .rst       (rst),
    .job_empty (job_empty),
    .job       (job_out),
    .job_pop   (job_pop),
    .thr       (thr),
    .res_full  (res_full),
    .res_push  (res_push),
    .res       (res_in)
  );

  wsd_fifo #(
    .WIDTH ($bits(result_t)),
    .DEPTH (QUEUE_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst   (rst),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (pop),
    .rdata (res_out),
    .empty (empty)
  );

  assign ready_res      = res_out.ready_res;
  assign leave_bed      = res_out.leave_bed;
  assign movement_level = res_out.movement_level;

endmodule

`default_nettype wire

@@ rtl/wsd_checker.sv @@
// Port-level checker of the window occupancy unit and its bind.
`default_nettype none

`include "window_stddev_occupancy_unit_defines.svh"

module wsd_checker import wsd_pkg::*; (
  input wire logic              clk,
  input wire logic              rst,
  input wire logic              full,
  input wire logic              empty,
  input wire logic              pop,
  input wire logic              ready_res,
  input wire logic              leave_bed,
  input wire logic [MOVE_W-1:0] movement_level
);

  `WSD_ASSERT_NOW(a_reset_clears, clk, 1'b0, $past(rst), empty && !full, "queues not clear after reset")

  `WSD_ASSERT_NOW(a_fill_zero, clk, rst, !empty && !ready_res, !leave_bed && (movement_level == '0), "result during fill carries data")

  `WSD_ASSERT_NEXT(a_ready_sticks, clk, rst, pop && !empty && ready_res, empty || ready_res, "result fell back to not ready")

  `WSD_ASSERT_NEXT(a_result_holds, clk, rst, !empty && !pop, !empty && $stable(ready_res) && $stable(leave_bed) && $stable(movement_level), "waiting result changed")

endmodule

bind window_stddev_occupancy_unit wsd_checker u_wsd_checker (
  .clk            (clk),
  .rst            (rst),
  .full           (full),
  .empty          (empty),
  .pop            (pop),
  .ready_res      (ready_res),
  .leave_bed      (leave_bed),
  .movement_level (movement_level)
);

`default_nettype wire

@@ sim/tb_top.sv @@
// Self-checking bench for the sliding-window occupancy and movement unit.
module tb_top;
  import wsd_pkg::*;

  localparam int WIN  = 10;
  localparam int FILL = 200;
  localparam int unsigned SAMPLE_MAX = (1 << SAMPLE_W) - 1;
  localparam int unsigned THRESH_MAX = (1 << THRESH_W) - 1;
  localparam longint unsigned SPREAD_LIM =
    longint'(MOVE_DIV * 256 * WIN) * longint'(MOVE_DIV * 256 * WIN);
  localparam logic [MOVE_W-1:0] MOVE_SAT = 8'd255;
  localparam int CYCLE_LIMIT   = 2_000_000;
  localparam int RANDOM_PHASES = 7;
  localparam int PHASE_ITEMS   = 160;
  localparam int TAIL_CYCLES   = 64;
  localparam int REPORT_MAX    = 10;

  typedef enum logic [1:0] {ROW_SAMPLE, ROW_RANDOM, ROW_CONFIG} row_kind_t;
  typedef enum logic [1:0] {MIX_WIDE, MIX_CALM, MIX_NEAR, MIX_EDGE} mix_t;

  typedef struct packed {
    row_kind_t           kind;
    logic [SAMPLE_W-1:0] value;
    logic [7:0]          reps;
    logic                typed;
    logic                want_ready;
    logic                want_leave;
    logic [MOVE_W-1:0]   want_move;
  } stim_row_t;

  // Typed expectation applies to the last word of a row.
  localparam int NROWS = 23;
  localparam stim_row_t DIRECTED [NROWS] = '{
    '{ROW_SAMPLE, 18'd0,       8'd1,   1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'h3FFFF,   8'd1,   1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd9000,    8'd1,   1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd9001,    8'd1,   1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_RANDOM, 18'd0,       8'd185, 1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd0,       8'd10,  1'b1, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd0,       8'd1,   1'b1, 1'b1, 1'b1, 8'd0},
    '{ROW_SAMPLE, 18'h3FFFF,   8'd1,   1'b1, 1'b1, 1'b0, 8'd255},
    '{ROW_SAMPLE, 18'd9000,    8'd10,  1'b1, 1'b1, 1'b1, 8'd0},
    '{ROW_SAMPLE, 18'd9001,    8'd1,   1'b1, 1'b1, 1'b0, 8'd0},
    '{ROW_CONFIG, 18'd0,       8'd1,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd0,       8'd10,  1'b1, 1'b1, 1'b1, 8'd0},
    '{ROW_SAMPLE, 18'd1,       8'd1,   1'b1, 1'b1, 1'b0, 8'd0},
    '{ROW_CONFIG, 18'h3FFFF,   8'd1,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'h3FFFF,   8'd10,  1'b1, 1'b1, 1'b1, 8'd0},
    '{ROW_SAMPLE, 18'd0,       8'd1,   1'b1, 1'b1, 1'b1, 8'd255},
    '{ROW_SAMPLE, 18'd1000,    8'd5,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd3000,    8'd5,   1'b1, 1'b1, 1'b1, 8'd100},
    '{ROW_SAMPLE, 18'd0,       8'd5,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd5120,    8'd5,   1'b1, 1'b1, 1'b1, 8'd255},
    '{ROW_SAMPLE, 18'd0,       8'd5,   1'b0, 1'b0, 1'b0, 8'd0},
    '{ROW_SAMPLE, 18'd5080,    8'd5,   1'b1, 1'b1, 1'b1, 8'd254},
    '{ROW_CONFIG, 18'd9000,    8'd1,   1'b0, 1'b0, 1'b0, 8'd0}
  };

  logic                clk;
  logic                rst;
  logic                push;
  logic                full;
  logic [SAMPLE_W-1:0] sample_sum;
  logic                empty;
  logic                pop;
  logic                ready_res;
  logic                leave_bed;
  logic [MOVE_W-1:0]   movement_level;
  logic                cfg_valid;
  logic                cfg_ready;
  logic [THRESH_W-1:0] cfg_data;

  window_stddev_occupancy_unit dut (
    .clk            (clk),
    .rst            (rst),
    .push           (push),
    .full           (full),
    .sample_sum     (sample_sum),
    .empty          (empty),
    .pop            (pop),
    .ready_res      (ready_res),
    .leave_bed      (leave_bed),
    .movement_level (movement_level),
    .cfg_valid      (cfg_valid),
    .cfg_ready      (cfg_ready),
    .cfg_data       (cfg_data)
  );

  // Occupancy model state
  logic [SAMPLE_W-1:0] ring_samples [WIN];
  int                  ring_wr;
  int                  fill_seen;
  logic [THRESH_W-1:0] thresh_model;
  result_t             pending_results [$];

  int  items_sent;
  int  results_seen;
  int  ready_seen;
  int  leave_seen;
  int  sat_seen;
  int  cfg_writes;
  int  mismatches;
  int  cycle_count;
  int  stall_left;
  bit  idle_en;

  initial clk = 1'b0;
  always #1 clk = ~clk;

  function automatic result_t predict_occupancy(logic [SAMPLE_W-1:0] s);
    result_t         r;
    longint unsigned spread_sum;
    longint unsigned diff;
    longint unsigned root;
    longint unsigned trial;
    r = '0;
    ring_samples[ring_wr] = s;
    ring_wr = (ring_wr == WIN - 1) ? 0 : ring_wr + 1;
    if (fill_seen < FILL) fill_seen++;
    if (fill_seen < FILL) return r;
    r.ready_res = 1'b1;
    r.leave_bed = 1'b1;
    spread_sum = 0;
    // Sum of squared differences over all pairs equals W*Q - S*S
    for (int i = 0; i < WIN; i++) begin
      if (ring_samples[i] > thresh_model) r.leave_bed = 1'b0;
      for (int j = i + 1; j < WIN; j++) begin
        if (ring_samples[i] > ring_samples[j])
          diff = longint'(ring_samples[i]) - longint'(ring_samples[j]);
        else
          diff = longint'(ring_samples[j]) - longint'(ring_samples[i]);
        spread_sum += diff * diff;
      end
    end
    if (spread_sum >= SPREAD_LIM) begin
      r.movement_level = MOVE_SAT;
    end else begin
      root = 0;
      for (int b = 15; b >= 0; b--) begin
        trial = root | (64'd1 << b);
        if (trial * trial <= spread_sum) root = trial;
      end
      r.movement_level = MOVE_W'(root / longint'(MOVE_DIV * WIN));
    end
    return r;
  endfunction

  function automatic int gap_cycles();
    int r;
    if (!idle_en) return 0;
    r = int'($urandom_range(0, 99));
    if (r < 55) return 0;
    if (r < 90) return int'($urandom_range(1, 3));
    if (r < 98) return int'($urandom_range(4, 12));
    return int'($urandom_range(30, 80));
  endfunction

  function automatic logic [SAMPLE_W-1:0] draw_sample(mix_t mix, int unsigned base,
                                                     int unsigned spread);
    int v;
    case (mix)
      MIX_WIDE: v = int'($urandom_range(0, SAMPLE_MAX));
      MIX_CALM: v = int'(base + $urandom_range(0, spread));
      MIX_NEAR: v = int'(thresh_model) + int'($urandom_range(0, 8)) - 4;
      default: begin
        case ($urandom_range(0, 5))
          0: v = 0;
          1: v = 1;
          2: v = int'(SAMPLE_MAX) - 1;
          3: v = int'(SAMPLE_MAX);
          4: v = int'(thresh_model);
          default: v = int'(thresh_model) + 1;
        endcase
      end
    endcase
    if (v < 0) v = 0;
    if (v > int'(SAMPLE_MAX)) v = int'(SAMPLE_MAX);
    return SAMPLE_W'(v);
  endfunction

  task automatic send_sample(logic [SAMPLE_W-1:0] s, bit typed, result_t want);
    int      gap;
    result_t r;
    gap = gap_cycles();
    if (gap > 0) begin
      push <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    push       <= 1'b1;
    sample_sum <= s;
    do @(posedge clk); while (full);
    r = predict_occupancy(s);
    pending_results.push_back(typed ? want : r);
    items_sent++;
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
  endtask

  task automatic write_threshold(logic [THRESH_W-1:0] v);
    drain_results();
    cfg_valid <= 1'b1;
    cfg_data  <= v;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid    <= 1'b0;
    thresh_model = v;
    cfg_writes++;
  endtask

  // Result side: check each popped word, then pick the next pop level
  always @(posedge clk) begin : result_mon
    result_t got;
    result_t want;
    if (rst) begin
      pop        <= 1'b0;
      stall_left = 0;
    end else begin
      if (pop && !empty) begin
        got = '{ready_res, leave_bed, movement_level};
        results_seen++;
        if (pending_results.size() == 0) begin
          mismatches++;
          if (mismatches <= REPORT_MAX)
            $display("MISMATCH %0d: word ready=%0b leave=%0b move=%0d with nothing pending",
                     mismatches, got.ready_res, got.leave_bed, got.movement_level);
        end else begin
          want = pending_results.pop_front();
          if (got !== want) begin
            mismatches++;
            if (mismatches <= REPORT_MAX)
              $display("MISMATCH %0d: exp ready/leave/move %0b/%0b/%0d, got %0b/%0b/%0d",
                       mismatches, want.ready_res, want.leave_bed, want.movement_level,
                       got.ready_res, got.leave_bed, got.movement_level);
          end
          if (got.ready_res === 1'b1) begin
            ready_seen++;
            if (got.leave_bed === 1'b1) leave_seen++;
            if (got.movement_level === MOVE_SAT) sat_seen++;
          end
        end
      end
      if (stall_left > 0) begin
        stall_left--;
        pop <= 1'b0;
      end else if (idle_en && $urandom_range(0, 99) < 20) begin
        stall_left = ($urandom_range(0, 19) == 0) ? int'($urandom_range(20, 60))
                                                  : int'($urandom_range(0, 3));
        pop <= 1'b0;
      end else begin
        pop <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles, %0d words still pending",
               cycle_count, pending_results.size());
      $display("Mismatches found");
      $finish;
    end
  end

  initial begin
    int          k;
    int          n;
    int          burst_left;
    int unsigned spread;
    int unsigned base;
    mix_t        mix;
    result_t     want;
    logic [THRESH_W-1:0] thresh_pick;

    rst        <= 1'b1;
    push       <= 1'b0;
    pop        <= 1'b0;
    sample_sum <= '0;
    cfg_valid  <= 1'b0;
    cfg_data   <= '0;
    for (int i = 0; i < WIN; i++) ring_samples[i] = '0;
    ring_wr      = 0;
    fill_seen    = 0;
    thresh_model = THRESH_RESET;
    items_sent   = 0;
    results_seen = 0;
    ready_seen   = 0;
    leave_seen   = 0;
    sat_seen     = 0;
    cfg_writes   = 0;
    mismatches   = 0;
    cycle_count  = 0;
    idle_en      = 1'b1;

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Directed table: fill phase, threshold edges, saturation and sqrt path
    for (int i = 0; i < NROWS; i++) begin
      want = '{DIRECTED[i].want_ready, DIRECTED[i].want_leave, DIRECTED[i].want_move};
      case (DIRECTED[i].kind)
        ROW_CONFIG: write_threshold(DIRECTED[i].value);
        ROW_RANDOM: begin
          for (k = 0; k < int'(DIRECTED[i].reps); k++)
            send_sample(SAMPLE_W'($urandom_range(0, SAMPLE_MAX)), 1'b0, want);
        end
        default: begin
          for (k = 0; k < int'(DIRECTED[i].reps); k++)
            send_sample(DIRECTED[i].value,
                        DIRECTED[i].typed && (k == int'(DIRECTED[i].reps) - 1), want);
        end
      endcase
    end

    // Random phases, each behind a fresh threshold written on a drained unit
    for (int p = 0; p < RANDOM_PHASES; p++) begin
      case (p)
        1: thresh_pick = '0;
        2: thresh_pick = THRESH_W'(THRESH_MAX);
        default: begin
          case ($urandom_range(0, 3))
            0: thresh_pick = THRESH_RESET;
            1: thresh_pick = THRESH_W'($urandom_range(0, 20000));
            default: thresh_pick = THRESH_W'($urandom_range(0, THRESH_MAX));
          endcase
        end
      endcase
      write_threshold(thresh_pick);
      idle_en    = (p % 3) != 1;
      burst_left = 0;
      for (n = 0; n < PHASE_ITEMS; n++) begin
        if (burst_left == 0) begin
          case ($urandom_range(0, 19))
            0, 1, 2, 3, 4:            mix = MIX_WIDE;
            5, 6, 7, 8, 9, 10, 11, 12: mix = MIX_CALM;
            13, 14, 15, 16, 17:       mix = MIX_NEAR;
            default:                  mix = MIX_EDGE;
          endcase
          case ($urandom_range(0, 2))
            0: spread = $urandom_range(0, 60);
            1: spread = $urandom_range(0, 3000);
            default: spread = $urandom_range(0, 12000);
          endcase
          base       = $urandom_range(0, SAMPLE_MAX - spread);
          burst_left = int'($urandom_range(5, 30));
        end
        send_sample(draw_sample(mix, base, spread), 1'b0, want);
        burst_left--;
      end
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);

    $display("Covered %0d samples across %0d threshold writes; %0d result words checked.",
             items_sent, cfg_writes, results_seen);
    $display("Ready words %0d, leave-bed set %0d, movement saturated %0d, errors %0d.",
             ready_seen, leave_seen, sat_seen, mismatches + pending_results.size());
    if (mismatches == 0 && pending_results.size() == 0)
      $display("No mismatches found");
    else
      $display("Mismatches found");
    $finish;
  end

endmodule
